[sv/peu_pkg.sv]
// shared types and constants for the polynomial easing unit
package peu_pkg;
	localparam int REG_IDX_BITS = 2;
	localparam logic [REG_IDX_BITS-1:0] REG_MODE     = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_START    = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_CHANGE   = 2'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_DURATION = 2'd3;
	localparam int CFG_DATA_BITS = 32;
	localparam int VALUE_BITS = 32;
	localparam int MODE_BITS = 4;
	localparam int MAX_DEG = 5;

	typedef enum logic [1:0] {
		KIND_LIN   = 2'd0,
		KIND_IN    = 2'd1,
		KIND_OUT   = 2'd2,
		KIND_INOUT = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] deg;
	} ease_ctl_t;

	// decode the mode register into curve kind and degree
	function automatic ease_ctl_t decode_mode(input logic [MODE_BITS-1:0] m);
		ease_ctl_t c;
		c.kind = KIND_LIN;
		c.deg  = 3'd1;
		unique case (m)
			4'd1:  begin c.kind = KIND_IN;    c.deg = 3'd2; end
			4'd2:  begin c.kind = KIND_OUT;   c.deg = 3'd2; end
			4'd3:  begin c.kind = KIND_INOUT; c.deg = 3'd2; end
			4'd4:  begin c.kind = KIND_IN;    c.deg = 3'd3; end
			4'd5:  begin c.kind = KIND_OUT;   c.deg = 3'd3; end
			4'd6:  begin c.kind = KIND_INOUT; c.deg = 3'd3; end
			4'd7:  begin c.kind = KIND_IN;    c.deg = 3'd4; end
			4'd8:  begin c.kind = KIND_OUT;   c.deg = 3'd4; end
			4'd9:  begin c.kind = KIND_INOUT; c.deg = 3'd4; end
			4'd10: begin c.kind = KIND_IN;    c.deg = 3'd5; end
			4'd11: begin c.kind = KIND_OUT;   c.deg = 3'd5; end
			4'd12: begin c.kind = KIND_INOUT; c.deg = 3'd5; end
			default: begin c.kind = KIND_LIN; c.deg = 3'd1; end
		endcase
		return c;
	endfunction
endpackage

[sv/peu_div.sv]
// pipelined restoring divider for normalized time, one quotient bit per stage
module peu_div #(
	parameter int TIME_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [TIME_BITS-1:0]   num,
	input  logic [TIME_BITS-1:0]   den,
	output logic                   out_valid,
	output logic [FRAC_BITS:0]     quot
);
	localparam int QB = FRAC_BITS + 1;
	localparam int RB = TIME_BITS + 1;

	// quotient of num*2^F/den with num<=den fits in F+1 bits
	logic [QB:0]          v_s;
	logic [RB-1:0]        rem_s [QB+1];
	logic [TIME_BITS-1:0] den_s [QB+1];
	logic [QB-1:0]        q_s   [QB+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = RB'(num);
	assign den_s[0] = den;
	assign q_s[0]   = '0;

	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic [RB-1:0] r2;
		logic [RB-1:0] diff;
		logic          ge;
		// stage 0 checks the integer bit without shifting
		assign r2   = (i == 0) ? rem_s[i] : {rem_s[i][RB-2:0], 1'b0};
		assign ge   = r2 >= RB'(den_s[i]);
		assign diff = r2 - RB'(den_s[i]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? diff : r2;
			den_s[i+1] <= den_s[i];
			q_s[i+1]   <= {q_s[i][QB-2:0], ge};
		end
	end

	assign out_valid = v_s[QB];
	assign quot      = q_s[QB];
endmodule

[sv/polynomial_easing_unit.sv]
// top level of the polynomial easing unit
// pipeline: FRAC_BITS+1 divider stages, 1 prep stage, 4 power stages,
// 1 finish stage, 2 scale stages, 1 sum stage
// throughput: one time word per cycle, every stage is a pipeline register
// the receiver cannot stall; done pulses one cycle per result word
// reset clears valid bits and loads register reset values
module polynomial_easing_unit #(
	parameter int TIME_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [TIME_BITS-1:0]                   current_time,
	output logic                                   done,
	output logic signed [peu_pkg::VALUE_BITS-1:0]  eased_value,
	output logic                                   saturated,
	input  logic                                   cfg_we,
	input  logic [peu_pkg::REG_IDX_BITS-1:0]       cfg_index,
	input  logic [peu_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
	import peu_pkg::*;

	localparam int UB = FRAC_BITS + 2;              // holds up to 2.0
	localparam int PB = FRAC_BITS + 1;              // polynomial up to 1.0
	localparam int MB = 2 * UB;
	localparam int CB = VALUE_BITS + PB + 1;
	localparam int SB = VALUE_BITS + 2;
	localparam logic [MB-1:0] HALF_M = MB'(1) << (FRAC_BITS - 1);
	localparam logic [UB-1:0] ONE_U = UB'(1) << FRAC_BITS;
	localparam logic [UB-1:0] HALF_U = UB'(1) << (FRAC_BITS - 1);

	// configuration registers
	logic [MODE_BITS-1:0]          mode_q;
	logic signed [VALUE_BITS-1:0]  start_q;
	logic signed [VALUE_BITS-1:0]  change_q;
	logic [TIME_BITS-1:0]          dur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			start_q  <= '0;
			change_q <= '0;
			dur_q    <= TIME_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q   <= cfg_data[MODE_BITS-1:0];
				REG_START:    start_q  <= cfg_data[VALUE_BITS-1:0];
				REG_CHANGE:   change_q <= cfg_data[VALUE_BITS-1:0];
				REG_DURATION: dur_q    <= TIME_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// clamp time and guard zero duration before the divider
	logic [TIME_BITS-1:0] d_eff, t_eff;
	assign d_eff = (dur_q == '0) ? TIME_BITS'(1) : dur_q;
	assign t_eff = (current_time > d_eff) ? d_eff : current_time;

	logic              dv;
	logic [FRAC_BITS:0] u;
	peu_div #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .num(t_eff), .den(d_eff),
		.out_valid(dv), .quot(u)
	);

	ease_ctl_t ctl;
	assign ctl = decode_mode(mode_q);

	// prep stage: pick the power base and whether to mirror / halve
	logic           v_s1;
	logic [UB-1:0]  x_s1, u_s1;
	ease_ctl_t      ctl_s1;
	logic           lo_s1;
	logic [UB-1:0]  uu;
	assign uu = UB'(u);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= dv;
		end
	end
	always_ff @(posedge clk) begin
		ctl_s1 <= ctl;
		u_s1   <= uu;
		lo_s1  <= uu < HALF_U;
		case (ctl.kind)
			KIND_IN:  x_s1 <= uu;
			KIND_OUT: x_s1 <= ONE_U - uu;
			KIND_INOUT: x_s1 <= (uu < HALF_U) ? (uu << 1) : ((ONE_U - uu) << 1);
			default:  x_s1 <= uu;
		endcase
	end

	// power stages: one rounded multiply each, degree 5 needs four
	localparam int NP = MAX_DEG - 1;
	logic          pv   [NP+1];
	logic [UB-1:0] px   [NP+1];
	logic [UB-1:0] pr   [NP+1];
	logic [UB-1:0] pu   [NP+1];
	ease_ctl_t     pc   [NP+1];
	logic          plo  [NP+1];
	assign pv[0] = v_s1;  assign px[0] = x_s1; assign pr[0] = x_s1;
	assign pu[0] = u_s1;  assign pc[0] = ctl_s1; assign plo[0] = lo_s1;

	for (genvar k = 0; k < NP; k++) begin : g_pow
		logic [MB-1:0] prod;
		assign prod = (MB'(pr[k]) * MB'(px[k]) + HALF_M) >> FRAC_BITS;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv[k+1] <= 1'b0;
			end else begin
				pv[k+1] <= pv[k];
			end
		end
		always_ff @(posedge clk) begin
			px[k+1]  <= px[k];
			pu[k+1]  <= pu[k];
			pc[k+1]  <= pc[k];
			plo[k+1] <= plo[k];
			// multiply only while below the wanted degree
			pr[k+1]  <= (3'(k + 2) <= pc[k].deg) ? UB'(prod) : pr[k];
		end
	end

	// finish stage: map power onto the curve
	logic          v_s2;
	logic [PB-1:0] p_s2;
	logic [UB-1:0] r_f, h_f;
	assign r_f = pr[NP];
	assign h_f = (r_f + UB'(1)) >> 1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= pv[NP];
		end
	end
	always_ff @(posedge clk) begin
		case (pc[NP].kind)
			KIND_IN:    p_s2 <= PB'(r_f);
			KIND_OUT:   p_s2 <= PB'(ONE_U - r_f);
			KIND_INOUT: p_s2 <= plo[NP] ? PB'(h_f) : PB'(ONE_U - h_f);
			default:    p_s2 <= PB'(pu[NP]);
		endcase
	end

	// scale stage: change times polynomial, then round
	logic                 v_s3, v_s4, v_s5;
	logic signed [CB-1:0] prod_s3;
	logic signed [CB-1:0] delta_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		prod_s3  <= CB'(change_q) * $signed({1'b0, p_s2});
		delta_s4 <= (prod_s3 + $signed(CB'(HALF_M))) >>> FRAC_BITS;
	end

	// sum and saturate
	logic signed [SB-1:0] sum;
	logic signed [SB-1:0] vmax, vmin;
	assign sum  = SB'(start_q) + SB'(delta_s4);
	assign vmax = SB'({1'b0, {(VALUE_BITS-1){1'b1}}});
	assign vmin = -vmax - SB'(1);
	logic signed [VALUE_BITS-1:0] val_s5;
	logic                         sat_s5;
	always_ff @(posedge clk) begin
		if (sum > vmax) begin
			val_s5 <= vmax[VALUE_BITS-1:0];
			sat_s5 <= 1'b1;
		end else if (sum < vmin) begin
			val_s5 <= vmin[VALUE_BITS-1:0];
			sat_s5 <= 1'b1;
		end else begin
			val_s5 <= sum[VALUE_BITS-1:0];
			sat_s5 <= 1'b0;
		end
	end

	assign done        = v_s5;
	assign eased_value = val_s5;
	assign saturated   = sat_s5;
endmodule

[dv/polynomial_easing_unit_test.sv]
// testbench for the polynomial easing unit: directed and random tweens checked against a predictor
`timescale 1ns / 100ps

module polynomial_easing_unit_test;
	import peu_pkg::*;

	localparam int TIME_BITS  = 16;
	localparam int FRAC_BITS  = 16;
	// drain wait, longer than the pipeline depth from the block header, with margin
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;
	localparam longint unsigned FX_ONE  = 64'd1 << FRAC_BITS;
	localparam longint unsigned FX_HALF = 64'd1 << (FRAC_BITS - 1);

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic [TIME_BITS-1:0]              current_time;
	logic                              done;
	logic signed [VALUE_BITS-1:0]      eased_value;
	logic                              saturated;
	logic                              cfg_we;
	logic [REG_IDX_BITS-1:0]           cfg_index;
	logic [CFG_DATA_BITS-1:0]          cfg_data;

	// one result word as the block should deliver it
	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		logic                         sat;
		logic [TIME_BITS-1:0]         tick;
	} eased_word_t;

	eased_word_t pending_words[$];

	// shadow copy of the configuration registers
	logic [MODE_BITS-1:0] shadow_mode;
	longint               shadow_start;
	longint               shadow_change;
	logic [TIME_BITS-1:0] shadow_duration;

	int unsigned sender_idle_pct;
	int          error_count;
	int          words_sent;
	int          words_checked;
	int          sat_seen;
	longint      cycle_count;

	polynomial_easing_unit #(
		.TIME_BITS(TIME_BITS),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.current_time(current_time),
		.done(done),
		.eased_value(eased_value),
		.saturated(saturated),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, a hung handshake or a lost word ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d words outstanding",
				$time, cycle_count, pending_words.size());
			$display("tb: failure");
			$finish;
		end
	end

	// fixed point multiply with ties rounded up
	function automatic longint unsigned fx_mul(input longint unsigned a, input longint unsigned b);
		return (a * b + FX_HALF) >> FRAC_BITS;
	endfunction

	// repeated multiplication, every product rounded
	function automatic longint unsigned fx_power(input longint unsigned x, input int deg);
		longint unsigned r;
		r = x;
		for (int i = 1; i < deg; i++) r = fx_mul(r, x);
		return r;
	endfunction

	// easing curve p(u) for the shadow mode
	function automatic longint unsigned curve_value(input longint unsigned u);
		kind_t           kind;
		int              deg;
		longint unsigned x;
		longint unsigned h;
		if (shadow_mode == 0 || shadow_mode > 12) return u;
		deg = (shadow_mode - 1) / 3 + 2;
		case ((shadow_mode - 1) % 3)
			0: kind = KIND_IN;
			1: kind = KIND_OUT;
			default: kind = KIND_INOUT;
		endcase
		case (kind)
			KIND_IN:  return fx_power(u, deg);
			KIND_OUT: return FX_ONE - fx_power(FX_ONE - u, deg);
			default: begin
				// halves meet at u = 1/2, the compare is exact
				if (u < FX_HALF) begin
					x = u << 1;
					h = (fx_power(x, deg) + 1) >> 1;
					return h;
				end
				x = (FX_ONE - u) << 1;
				h = (fx_power(x, deg) + 1) >> 1;
				return FX_ONE - h;
			end
		endcase
	endfunction

	// tween value for one tick under the shadow configuration
	function automatic eased_word_t predict_tween(input logic [TIME_BITS-1:0] tick);
		eased_word_t     w;
		longint unsigned d;
		longint unsigned t;
		longint unsigned u;
		longint          prod;
		longint          sum;
		// zero duration acts as one tick, late ticks clamp to the end
		d = (shadow_duration == 0) ? 1 : shadow_duration;
		t = tick;
		if (t > d) t = d;
		u = (t << FRAC_BITS) / d;
		prod = shadow_change * longint'(curve_value(u)) + longint'(FX_HALF);
		sum = shadow_start + (prod >>> FRAC_BITS);
		w.sat = 1'b0;
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
			w.sat = 1'b1;
		end else if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
			w.sat = 1'b1;
		end
		w.value = sum[31:0];
		w.tick = tick;
		return w;
	endfunction

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		eased_word_t exp_w;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$display("%0t unexpected word: value %0d sat %0b", $time, eased_value, saturated);
				error_count++;
			end else begin
				exp_w = pending_words.pop_front();
				words_checked++;
				if (exp_w.sat) sat_seen++;
				if (eased_value !== exp_w.value) begin
					$display("%0t eased_value mismatch at tick %0d: expected %0d actual %0d",
						$time, exp_w.tick, exp_w.value, eased_value);
					error_count++;
				end
				if (saturated !== exp_w.sat) begin
					$display("%0t saturated mismatch at tick %0d: expected %0b actual %0b",
						$time, exp_w.tick, exp_w.sat, saturated);
					error_count++;
				end
			end
		end
	end

	// hand one time word to the block, start stays high if another follows soon
	task automatic send_tick(input logic [TIME_BITS-1:0] tick);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		current_time = tick;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pending_words.push_back(predict_tween(tick));
		words_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	// let every expected word come back and the pipe run empty
	task automatic drain_pipe();
		start = 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// register write, only called with the pipe idle
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		case (idx)
			REG_MODE:     shadow_mode = data[MODE_BITS-1:0];
			REG_START:    shadow_start = longint'($signed(data));
			REG_CHANGE:   shadow_change = longint'($signed(data));
			REG_DURATION: shadow_duration = data[TIME_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_tween(input logic [MODE_BITS-1:0] mode, input logic [31:0] from,
			input logic [31:0] delta, input logic [TIME_BITS-1:0] dur);
		drain_pipe();
		write_reg(REG_MODE, 32'(mode));
		write_reg(REG_START, from);
		write_reg(REG_CHANGE, delta);
		write_reg(REG_DURATION, 32'(dur));
	endtask

	// reset values: zero start and change give zero everywhere
	task automatic test_reset_values();
		send_tick('0);
		send_tick(16'd1);
		send_tick('1);
	endtask

	// every mode once, unused modes too, plus end points and overflow
	task automatic test_directed_modes();
		for (int m = 0; m < 16; m++) begin
			set_tween(MODE_BITS'(m), 32'h0001_0000, 32'h0064_0000, 16'd100);
			send_tick(16'd37);
			if (m == 3 || m == 9) send_tick(16'd50);
		end
		set_tween(4'd12, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
		send_tick('0);
		send_tick(16'hffff);
		send_tick(16'h7fff);
		// zero duration behaves as one tick
		set_tween(4'd0, 32'h0, 32'h0001_0000, 16'd0);
		send_tick('0);
		send_tick(16'd5);
		// overflow both ways
		set_tween(4'd2, 32'h7fff_0000, 32'h7fff_ffff, 16'd10);
		send_tick(16'd9);
		set_tween(4'd1, 32'h8000_0000, 32'h8000_0000, 16'd10);
		send_tick(16'd10);
	endtask

	function automatic logic [31:0] random_q16();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(2000)) - 1000) << 16;
			default: return $urandom();
		endcase
	endfunction

	// random tweens, phases cycle through the sender idle settings
	task automatic test_random_tweens();
		int unsigned idle_sets[3] = '{0, 72, 8};
		logic [TIME_BITS-1:0] dur;
		logic [TIME_BITS-1:0] tick;
		for (int ph = 0; ph < 20; ph++) begin
			case ($urandom_range(9))
				0: dur = 16'hffff;
				1: dur = 16'd0;
				2: dur = 16'd1;
				3, 4: dur = TIME_BITS'($urandom());
				default: dur = TIME_BITS'($urandom_range(2, 300));
			endcase
			set_tween(MODE_BITS'($urandom_range(15)), random_q16(), random_q16(), dur);
			sender_idle_pct = idle_sets[ph % 3];
			for (int i = 0; i < 52; i++) begin
				if ($urandom_range(3) == 0) tick = TIME_BITS'($urandom());
				else tick = TIME_BITS'($urandom_range(0, int'(dur) + 2));
				send_tick(tick);
				// hold off once until every word is back
				if (ph == 4 && i == 25) begin
					start = 1'b0;
					while (pending_words.size() != 0) @(negedge clk);
				end
			end
		end
		sender_idle_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		current_time = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		cycle_count = 0;
		error_count = 0;
		words_sent = 0;
		words_checked = 0;
		sat_seen = 0;
		sender_idle_pct = 0;
		shadow_mode = '0;
		shadow_start = 0;
		shadow_change = 0;
		shadow_duration = 16'd1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_directed_modes();
		test_random_tweens();
		drain_pipe();

		$display("run covered %0d time words over all sixteen mode codes, %0d results checked",
			words_sent, words_checked);
		$display("%0d results saturated, sender idling at 0, 72 and 8 percent", sat_seen);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d errors", error_count);
			$display("tb: failure");
		end
		$finish;
	end
endmodule
